[hdl/setx_pkg.sv]
// Shared types and constants for the sprite entry tile expander.
package setx_pkg;

    localparam int MAX_TILES_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int HEIGHT_W      = 3;

    localparam logic [9:0] SY_BASE_LO = 10'd240;
    localparam logic [9:0] SY_BASE_HI = 10'd495;
    localparam logic [8:0] SX_WRAP    = 9'h17f;
    localparam logic [9:0] SX_SPAN    = 10'h200;

    typedef struct packed {
        logic [15:0]         base_tile;
        logic [HEIGHT_W-1:0] last_row;
        logic [3:0]          colour;
        logic                flip_x;
        logic                flip_y;
        logic signed [9:0]   sx;
        logic signed [9:0]   sy;
    } t_tile_desc;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

[hdl/setx_front.sv]
// Entry front end: accepts an entry, drops disabled ones, derives the tile column descriptor.
module setx_front #(
    parameter int MAX_TILES = setx_pkg::MAX_TILES_DEF
) (
    input  logic                 start,
    input  logic                 i_full,
    input  logic [7:0]           i_y_pos,
    input  logic [7:0]           i_attr_bits,
    input  logic [7:0]           i_tile_low,
    input  logic [7:0]           i_tile_bank,
    input  logic [3:0]           i_palette_sel,
    input  logic [7:0]           i_x_pos,
    output logic                 o_push,
    output setx_pkg::t_tile_desc o_desc
);

    localparam logic [setx_pkg::HEIGHT_W-1:0] LAST_MAX = setx_pkg::HEIGHT_W'(MAX_TILES - 1);

    logic [setx_pkg::HEIGHT_W-1:0] height;
    logic [8:0]                    x9;

    assign height = i_attr_bits[7:5];
    assign x9     = {i_attr_bits[2], i_x_pos};

    assign o_push = start && !i_full && i_attr_bits[0];

    always_comb begin
        o_desc.base_tile = {i_tile_bank, i_tile_low};
        o_desc.last_row  = (height > LAST_MAX) ? LAST_MAX : height;
        o_desc.colour    = i_palette_sel;
        o_desc.flip_x    = i_attr_bits[4];
        o_desc.flip_y    = i_attr_bits[3];
        if (x9 > setx_pkg::SX_WRAP) begin
            o_desc.sx = $signed({1'b0, x9} - setx_pkg::SX_SPAN);
        end else begin
            o_desc.sx = $signed({1'b0, x9});
        end
        if (i_attr_bits[1]) begin
            o_desc.sy = $signed(setx_pkg::SY_BASE_HI - {2'b00, i_y_pos});
        end else begin
            o_desc.sy = $signed(setx_pkg::SY_BASE_LO - {2'b00, i_y_pos});
        end
    end

endmodule

[hdl/setx_queue.sv]
// Short descriptor queue between the front end and the tile emitter.
module setx_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  setx_pkg::t_tile_desc i_desc,
    input  logic                 i_pop,
    output setx_pkg::t_tile_desc o_desc,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PTR_W = (setx_pkg::QUEUE_DEPTH > 1) ? $clog2(setx_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(setx_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(setx_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(setx_pkg::QUEUE_DEPTH - 1);

    setx_pkg::t_tile_desc r_slot [setx_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == DEPTH_C);
    assign o_desc  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_P) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_P) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

endmodule

[hdl/setx_back.sv]
// Tile emitter: walks each descriptor row by row, one tile command beat per cycle.
module setx_back #(
    parameter int MAX_TILES = setx_pkg::MAX_TILES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  setx_pkg::t_tile_desc i_desc,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [16:0]          o_tile_index,
    output logic [3:0]           o_tile_colour,
    output logic                 o_mirror_x,
    output logic                 o_mirror_y,
    output logic signed [9:0]    o_screen_x,
    output logic signed [9:0]    o_screen_y,
    output logic                 o_final_tile
);

    localparam int ROW_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

    setx_pkg::t_back_state r_state, n_state;
    setx_pkg::t_tile_desc  r_desc;
    logic [ROW_W-1:0]      r_row, n_row;
    logic                  row_last;
    logic                  load;

    assign row_last = (r_row == ROW_W'(r_desc.last_row));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            setx_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = setx_pkg::BK_EMIT;
                end
            end
            setx_pkg::BK_EMIT: begin
                if (row_last && i_empty) begin
                    n_state = setx_pkg::BK_IDLE;
                end
            end
            default: n_state = setx_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        load  = 1'b0;
        n_row = r_row;
        unique case (r_state)
            setx_pkg::BK_IDLE: begin
                load  = !i_empty;
                n_row = '0;
            end
            setx_pkg::BK_EMIT: begin
                load  = row_last && !i_empty;
                n_row = row_last ? '0 : r_row + 1'b1;
            end
            default: begin
                load  = 1'b0;
                n_row = '0;
            end
        endcase
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= setx_pkg::BK_IDLE;
            r_row   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            o_valid <= (r_state == setx_pkg::BK_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_desc;
        end
        o_tile_index  <= {1'b0, r_desc.base_tile} + 17'(r_row);
        o_tile_colour <= r_desc.colour;
        o_mirror_x    <= r_desc.flip_x;
        o_mirror_y    <= r_desc.flip_y;
        o_screen_x    <= r_desc.sx;
        o_screen_y    <= r_desc.sy - $signed({2'b00, 4'(r_row), 4'b0000});
        o_final_tile  <= row_last;
    end

`ifndef SYNTHESIS
    a_emit_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == setx_pkg::BK_EMIT) |=> o_valid)
        else $error("emit cycle produced no beat");
    a_more_rows_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_tile) |-> (r_state == setx_pkg::BK_EMIT))
        else $error("column ended before its final tile");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");
    a_no_reload_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == setx_pkg::BK_EMIT && !row_last) |-> !o_pop)
        else $error("descriptor reloaded mid column");
`endif

endmodule

[hdl/sprite_entry_tile_expander.sv]
// Top level of the sprite entry tile expander.
//
//  channel  | handshake       | payload
//  ---------+-----------------+------------------------------------------------
//  entry in | start / busy    | i_y_pos i_attr_bits i_tile_low i_tile_bank
//           |                 | i_palette_sel i_x_pos
//  tile out | o_valid strobe  | o_tile_index o_tile_colour o_mirror_x o_mirror_y
//           |                 | o_screen_x o_screen_y o_final_tile
//
// An enabled entry yields min(height+1, MAX_TILES) beats, one per cycle, set by the
// row counter of the emitter; a disabled entry is dropped at once and yields none.
// When the emitter is free, an entry goes via the queue, r_desc and output registers.
// A two-entry descriptor queue lets entries be taken while a column is emitted;
// busy is high while that queue is full.
// Reset is synchronous, active low, and empties the queue and the emitter.
// The receiver cannot stall: every beat is shown for exactly one cycle.
module sprite_entry_tile_expander #(
    parameter int MAX_TILES = setx_pkg::MAX_TILES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        i_y_pos,
    input  logic [7:0]        i_attr_bits,
    input  logic [7:0]        i_tile_low,
    input  logic [7:0]        i_tile_bank,
    input  logic [3:0]        i_palette_sel,
    input  logic [7:0]        i_x_pos,
    output logic              o_valid,
    output logic [16:0]       o_tile_index,
    output logic [3:0]        o_tile_colour,
    output logic              o_mirror_x,
    output logic              o_mirror_y,
    output logic signed [9:0] o_screen_x,
    output logic signed [9:0] o_screen_y,
    output logic              o_final_tile
);

    setx_pkg::t_tile_desc push_desc;
    setx_pkg::t_tile_desc head_desc;
    logic                 push;
    logic                 pop;
    logic                 empty;
    logic                 full;

    assign busy = full;

    setx_front #(
        .MAX_TILES (MAX_TILES)
    ) u_front (
        .start         (start),
        .i_full        (full),
        .i_y_pos       (i_y_pos),
        .i_attr_bits   (i_attr_bits),
        .i_tile_low    (i_tile_low),
        .i_tile_bank   (i_tile_bank),
        .i_palette_sel (i_palette_sel),
        .i_x_pos       (i_x_pos),
        .o_push        (push),
        .o_desc        (push_desc)
    );

    setx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_empty (empty),
        .o_full  (full)
    );

    setx_back #(
        .MAX_TILES (MAX_TILES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc        (head_desc),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_tile_index  (o_tile_index),
        .o_tile_colour (o_tile_colour),
        .o_mirror_x    (o_mirror_x),
        .o_mirror_y    (o_mirror_y),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_final_tile  (o_final_tile)
    );

endmodule
